### rtl/core/assert_macros.svh
// Assertion macros for the RTL files that check their own logic; the diff engine includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside of reset.
`define LLD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checked on every rising clock edge, reset included.
`define LLD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

### rtl/core/lld_pkg.sv
// Types and constants shared by the line diff engine modules.
package lld_pkg;

    localparam int MAX_LINES = 32;
    localparam int TAG_BITS  = 32;
    localparam int IDX_W     = 5;
    localparam int CNT_W     = 6;
    localparam int LEN_W     = 6;
    localparam int TBL_AW    = 2 * IDX_W;

    localparam logic [1:0] FUNC_LOAD_OLD = 2'd0;
    localparam logic [1:0] FUNC_LOAD_NEW = 2'd1;
    localparam logic [1:0] FUNC_COMPUTE  = 2'd2;

    typedef enum logic [1:0] {
        OP_KEEP   = 2'd0,
        OP_ADD    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_EMPTY  = 2'd3
    } t_edit_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ROW,
        ST_FILL,
        ST_DRAIN,
        ST_LEN,
        ST_LENCAP,
        ST_TRD,
        ST_TDEC,
        ST_EMPTY
    } t_state;

    // Requests to the two line memories.
    typedef struct packed {
        logic                we;
        logic                we_new;
        logic [IDX_W-1:0]    waddr;
        logic [TAG_BITS-1:0] wdata;
        logic                old_re;
        logic [IDX_W-1:0]    old_raddr;
        logic                new_re;
        logic [IDX_W-1:0]    new_raddr;
    } t_line_req;

    // Requests to the LCS table memory.
    typedef struct packed {
        logic              we;
        logic [TBL_AW-1:0] waddr;
        logic [LEN_W-1:0]  wdata;
        logic              re;
        logic [TBL_AW-1:0] raddr_a;
        logic [TBL_AW-1:0] raddr_b;
    } t_tbl_req;

endpackage

### rtl/core/lld_line_store.sv
// Old-file and new-file line tag memories with registered read data.
module lld_line_store import lld_pkg::*; (
    input  logic                i_clk,
    input  t_line_req           i_req,
    output logic [TAG_BITS-1:0] o_old_q,
    output logic [TAG_BITS-1:0] o_new_q
);

    logic [TAG_BITS-1:0] r_old_mem [MAX_LINES];
    logic [TAG_BITS-1:0] r_new_mem [MAX_LINES];
    logic [TAG_BITS-1:0] r_old_q;
    logic [TAG_BITS-1:0] r_new_q;

    always_ff @(posedge i_clk) begin
        if (i_req.we && !i_req.we_new) begin
            r_old_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.old_re) begin
            r_old_q <= r_old_mem[i_req.old_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.we && i_req.we_new) begin
            r_new_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.new_re) begin
            r_new_q <= r_new_mem[i_req.new_raddr];
        end
    end

    assign o_old_q = r_old_q;
    assign o_new_q = r_new_q;

endmodule

### rtl/core/lld_table.sv
// LCS table memory: one write port and two registered read ports.
module lld_table import lld_pkg::*; (
    input  logic             i_clk,
    input  t_tbl_req         i_req,
    output logic [LEN_W-1:0] o_qa,
    output logic [LEN_W-1:0] o_qb
);

    localparam int DEPTH = 1 << TBL_AW;

    logic [LEN_W-1:0] r_mem [DEPTH];
    logic [LEN_W-1:0] r_qa;
    logic [LEN_W-1:0] r_qb;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_qa <= r_mem[i_req.raddr_a];
            r_qb <= r_mem[i_req.raddr_b];
        end
    end

    assign o_qa = r_qa;
    assign o_qb = r_qb;

endmodule

### rtl/core/line_lcs_diff_engine.sv
// Line diff engine: two line stores, the LCS table and its fill and trace control.
//
// Input channel s_axis: tuser carries the function (load old line, load new line,
// compute), tdata the 32-bit line tag. Load items are accepted back to back while
// idle; a load into a full sequence of 32 lines is dropped, and function code 3 is
// ignored. With both sequences loaded, a compute item fills the LCS table row by
// row, one cell per cycle; each row opens with a read of its old line and closes
// with a drain state. The cell rate is set by the single read-modify-write path
// through the table memory. The LCS length is then fetched (states ST_LEN and
// ST_LENCAP), and the traceback spends a memory read and a decision on each
// emitted operation. Both sequences empty gives a single result.
// Output channel m_axis: tuser carries the edit operation, tdata the old index,
// new index and LCS length, tlast marks the final operation of a diff.
// Operations come out from the end of the files toward the start.
// A registered output stage holds each result; when the receiver stalls, the
// traceback waits on it. No input item is taken during a compute.
// Reset empties both sequences and drops any pending result; the memories are
// not cleared, since only written entries are ever used.
module line_lcs_diff_engine import lld_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] line_tag
    input  logic [1:0]  s_axis_tuser,   // [1:0] func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [4:0] old_index, [9:5] new_index, [15:10] lcs_length
    output logic [1:0]  m_axis_tuser,   // [1:0] edit_op
    output logic        m_axis_tlast    // last
);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_old_cnt, n_old_cnt;
    logic [CNT_W-1:0] r_new_cnt, n_new_cnt;
    logic [CNT_W-1:0] r_ri, n_ri;
    logic [CNT_W-1:0] r_cj, n_cj;
    logic             r_p1_vld, n_p1_vld;
    logic [CNT_W-1:0] r_p1_j, n_p1_j;
    logic [LEN_W-1:0] r_left, n_left;
    logic [LEN_W-1:0] r_diag, n_diag;
    logic [CNT_W-1:0] r_ti, n_ti;
    logic [CNT_W-1:0] r_tj, n_tj;
    logic [LEN_W-1:0] r_len, n_len;
    logic             r_out_vld, n_out_vld;
    t_edit_op         r_out_op, n_out_op;
    logic [IDX_W-1:0] r_out_oi, n_out_oi;
    logic [IDX_W-1:0] r_out_ni, n_out_ni;
    logic [LEN_W-1:0] r_out_len, n_out_len;
    logic             r_out_last, n_out_last;

    t_line_req           line_req;
    t_tbl_req            tbl_req;
    logic [TAG_BITS-1:0] old_q;
    logic [TAG_BITS-1:0] new_q;
    logic [LEN_W-1:0]    tbl_qa;
    logic [LEN_W-1:0]    tbl_qb;

    logic             in_acc;
    logic             out_free;
    logic             tags_eq;
    logic [LEN_W-1:0] fill_up;
    logic [LEN_W-1:0] fill_val;
    logic [LEN_W-1:0] tr_up;
    logic [LEN_W-1:0] tr_left;
    logic [CNT_W-1:0] ri_m1, ri_m2, cj_m1;
    logic [CNT_W-1:0] ti_m1, ti_m2, tj_m1, tj_m2;
    logic [CNT_W-1:0] p1_j_m1, oc_m1, nc_m1;

    lld_line_store u_lines (
        .i_clk   (i_clk),
        .i_req   (line_req),
        .o_old_q (old_q),
        .o_new_q (new_q)
    );

    lld_table u_table (
        .i_clk (i_clk),
        .i_req (tbl_req),
        .o_qa  (tbl_qa),
        .o_qb  (tbl_qb)
    );

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_vld || m_axis_tready;

    assign ri_m1   = r_ri - CNT_W'(1);
    assign ri_m2   = r_ri - CNT_W'(2);
    assign cj_m1   = r_cj - CNT_W'(1);
    assign ti_m1   = r_ti - CNT_W'(1);
    assign ti_m2   = r_ti - CNT_W'(2);
    assign tj_m1   = r_tj - CNT_W'(1);
    assign tj_m2   = r_tj - CNT_W'(2);
    assign p1_j_m1 = r_p1_j - CNT_W'(1);
    assign oc_m1   = r_old_cnt - CNT_W'(1);
    assign nc_m1   = r_new_cnt - CNT_W'(1);

    // Row zero and column zero of the table are all zero and are never stored;
    // cell (i, j) lives at address {i-1, j-1}.
    assign tags_eq  = (old_q == new_q);
    assign fill_up  = (r_ri == CNT_W'(1)) ? '0 : tbl_qa;
    assign fill_val = tags_eq ? (r_diag + LEN_W'(1)) : ((fill_up > r_left) ? fill_up : r_left);
    assign tr_up    = (r_ti == CNT_W'(1)) ? '0 : tbl_qa;
    assign tr_left  = (r_tj == CNT_W'(1)) ? '0 : tbl_qb;

    always_comb begin
        n_state    = r_state;
        n_old_cnt  = r_old_cnt;
        n_new_cnt  = r_new_cnt;
        n_ri       = r_ri;
        n_cj       = r_cj;
        n_p1_vld   = 1'b0;
        n_p1_j     = r_p1_j;
        n_left     = r_left;
        n_diag     = r_diag;
        n_ti       = r_ti;
        n_tj       = r_tj;
        n_len      = r_len;
        n_out_vld  = r_out_vld && !m_axis_tready;
        n_out_op   = r_out_op;
        n_out_oi   = r_out_oi;
        n_out_ni   = r_out_ni;
        n_out_len  = r_out_len;
        n_out_last = r_out_last;

        line_req           = '0;
        line_req.wdata     = s_axis_tdata[TAG_BITS-1:0];
        line_req.we_new    = (s_axis_tuser == FUNC_LOAD_NEW);
        line_req.waddr     = (s_axis_tuser == FUNC_LOAD_NEW) ? r_new_cnt[IDX_W-1:0]
                                                             : r_old_cnt[IDX_W-1:0];
        tbl_req            = '0;
        tbl_req.waddr      = {ri_m1[IDX_W-1:0], p1_j_m1[IDX_W-1:0]};
        tbl_req.wdata      = fill_val;

        // Cell computation for the read issued in the previous cycle.
        if (r_p1_vld) begin
            tbl_req.we = 1'b1;
            n_left     = fill_val;
            n_diag     = fill_up;
        end

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    case (s_axis_tuser)
                        FUNC_LOAD_OLD: begin
                            if (r_old_cnt < CNT_W'(MAX_LINES)) begin
                                line_req.we = 1'b1;
                                n_old_cnt   = r_old_cnt + CNT_W'(1);
                            end
                        end
                        FUNC_LOAD_NEW: begin
                            if (r_new_cnt < CNT_W'(MAX_LINES)) begin
                                line_req.we = 1'b1;
                                n_new_cnt   = r_new_cnt + CNT_W'(1);
                            end
                        end
                        FUNC_COMPUTE: begin
                            if (r_old_cnt == '0 && r_new_cnt == '0) begin
                                n_state = ST_EMPTY;
                            end else if (r_old_cnt == '0 || r_new_cnt == '0) begin
                                n_state = ST_LEN;
                            end else begin
                                n_ri    = CNT_W'(1);
                                n_state = ST_ROW;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_ROW: begin
                line_req.old_re    = 1'b1;
                line_req.old_raddr = ri_m1[IDX_W-1:0];
                n_cj               = CNT_W'(1);
                n_left             = '0;
                n_diag             = '0;
                n_state            = ST_FILL;
            end
            ST_FILL: begin
                tbl_req.re         = 1'b1;
                tbl_req.raddr_a    = {ri_m2[IDX_W-1:0], cj_m1[IDX_W-1:0]};
                line_req.new_re    = 1'b1;
                line_req.new_raddr = cj_m1[IDX_W-1:0];
                n_p1_vld           = 1'b1;
                n_p1_j             = r_cj;
                n_cj               = r_cj + CNT_W'(1);
                if (r_cj == r_new_cnt) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (r_ri == r_old_cnt) begin
                    n_state = ST_LEN;
                end else begin
                    n_ri    = r_ri + CNT_W'(1);
                    n_state = ST_ROW;
                end
            end
            ST_LEN: begin
                tbl_req.re      = 1'b1;
                tbl_req.raddr_a = {oc_m1[IDX_W-1:0], nc_m1[IDX_W-1:0]};
                n_state         = ST_LENCAP;
            end
            ST_LENCAP: begin
                n_len   = (r_old_cnt == '0 || r_new_cnt == '0) ? '0 : tbl_qa;
                n_ti    = r_old_cnt;
                n_tj    = r_new_cnt;
                n_state = ST_TRD;
            end
            ST_TRD: begin
                line_req.old_re    = 1'b1;
                line_req.old_raddr = ti_m1[IDX_W-1:0];
                line_req.new_re    = 1'b1;
                line_req.new_raddr = tj_m1[IDX_W-1:0];
                tbl_req.re         = 1'b1;
                tbl_req.raddr_a    = {ti_m2[IDX_W-1:0], tj_m1[IDX_W-1:0]};
                tbl_req.raddr_b    = {ti_m1[IDX_W-1:0], tj_m2[IDX_W-1:0]};
                n_state            = ST_TDEC;
            end
            ST_TDEC: begin
                if (out_free) begin
                    n_out_vld = 1'b1;
                    n_out_len = r_len;
                    n_out_oi  = '0;
                    n_out_ni  = '0;
                    // A keep steps diagonally; on a tie between the two
                    // neighbors the walk prefers an add.
                    if (r_ti == '0) begin
                        n_out_op = OP_ADD;
                        n_out_ni = tj_m1[IDX_W-1:0];
                        n_tj     = tj_m1;
                    end else if (r_tj == '0) begin
                        n_out_op = OP_REMOVE;
                        n_out_oi = ti_m1[IDX_W-1:0];
                        n_ti     = ti_m1;
                    end else if (tags_eq) begin
                        n_out_op = OP_KEEP;
                        n_out_oi = ti_m1[IDX_W-1:0];
                        n_out_ni = tj_m1[IDX_W-1:0];
                        n_ti     = ti_m1;
                        n_tj     = tj_m1;
                    end else if (tr_up <= tr_left) begin
                        n_out_op = OP_ADD;
                        n_out_ni = tj_m1[IDX_W-1:0];
                        n_tj     = tj_m1;
                    end else begin
                        n_out_op = OP_REMOVE;
                        n_out_oi = ti_m1[IDX_W-1:0];
                        n_ti     = ti_m1;
                    end
                    n_out_last = (n_ti == '0 && n_tj == '0);
                    if (n_out_last) begin
                        n_old_cnt = '0;
                        n_new_cnt = '0;
                        n_state   = ST_IDLE;
                    end else begin
                        n_state = ST_TRD;
                    end
                end
            end
            ST_EMPTY: begin
                if (out_free) begin
                    n_out_vld  = 1'b1;
                    n_out_op   = OP_EMPTY;
                    n_out_oi   = '0;
                    n_out_ni   = '0;
                    n_out_len  = '0;
                    n_out_last = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_old_cnt <= '0;
            r_new_cnt <= '0;
            r_p1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_old_cnt <= n_old_cnt;
            r_new_cnt <= n_new_cnt;
            r_p1_vld  <= n_p1_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ri       <= n_ri;
        r_cj       <= n_cj;
        r_p1_j     <= n_p1_j;
        r_left     <= n_left;
        r_diag     <= n_diag;
        r_ti       <= n_ti;
        r_tj       <= n_tj;
        r_len      <= n_len;
        r_out_op   <= n_out_op;
        r_out_oi   <= n_out_oi;
        r_out_ni   <= n_out_ni;
        r_out_len  <= n_out_len;
        r_out_last <= n_out_last;
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tuser  = r_out_op;
    assign m_axis_tdata  = {r_out_len, r_out_ni, r_out_oi};
    assign m_axis_tlast  = r_out_last;

`include "assert_macros.svh"

    `LLD_ASSERT(a_cnt_range, (r_old_cnt <= CNT_W'(MAX_LINES)) && (r_new_cnt <= CNT_W'(MAX_LINES)), "line count above capacity")
    `LLD_ASSERT(a_fill_col, r_p1_vld |-> (r_p1_j != '0) && (r_p1_j <= r_new_cnt) && (r_ri != '0) && (r_ri <= r_old_cnt), "fill cell outside the loaded sequences")
    `LLD_ASSERT(a_trace_pos, (r_state == ST_TRD) |-> (r_ti <= r_old_cnt) && (r_tj <= r_new_cnt) && !(r_ti == '0 && r_tj == '0), "traceback position out of range")
    `LLD_ASSERT(a_empty_last, (m_axis_tvalid && m_axis_tuser == OP_EMPTY) |-> m_axis_tlast && (m_axis_tdata == '0), "empty-diff result must be a lone final item")

endmodule

### tb/line_lcs_diff_engine_tb.sv
// Self-checking testbench for the line diff engine: loads line tags, runs diffs, checks each edit.
`timescale 1ns / 100ps

module line_lcs_diff_engine_tb;
    import lld_pkg::*;

    localparam logic [1:0] FUNC_IGNORED = 2'd3;
    localparam int         ITEM_TARGET  = 210;
    localparam int         CYCLE_LIMIT  = 300000;

    typedef struct packed {
        t_edit_op         op;
        logic [IDX_W-1:0] old_idx;
        logic [IDX_W-1:0] new_idx;
        logic [LEN_W-1:0] lcs_len;
        logic             last;
    } t_edit_rec;

    // Keeps its own copy of both sequences and the queue of edits still owed by the block.
    class diff_scoreboard;
        logic [TAG_BITS-1:0] old_tags [MAX_LINES];
        logic [TAG_BITS-1:0] new_tags [MAX_LINES];
        int unsigned         old_cnt;
        int unsigned         new_cnt;
        t_edit_rec           expected_ops [$];
        int unsigned         errors;

        function new();
            old_cnt = 0;
            new_cnt = 0;
            errors  = 0;
        endfunction

        function int unsigned pending();
            return expected_ops.size();
        endfunction

        function void note_item(input logic [1:0] func, input logic [TAG_BITS-1:0] tag);
            int unsigned lcs [MAX_LINES+1][MAX_LINES+1];
            int unsigned i;
            int unsigned j;
            int unsigned len;
            t_edit_rec   rec;
            case (func)
                FUNC_LOAD_OLD: begin
                    if (old_cnt < MAX_LINES) begin
                        old_tags[old_cnt] = tag;
                        old_cnt++;
                    end
                end
                FUNC_LOAD_NEW: begin
                    if (new_cnt < MAX_LINES) begin
                        new_tags[new_cnt] = tag;
                        new_cnt++;
                    end
                end
                FUNC_COMPUTE: begin
                    for (i = 0; i <= old_cnt; i++) begin
                        for (j = 0; j <= new_cnt; j++) begin
                            if (i == 0 || j == 0)
                                lcs[i][j] = 0;
                            else if (old_tags[i-1] == new_tags[j-1])
                                lcs[i][j] = lcs[i-1][j-1] + 1;
                            else
                                lcs[i][j] = (lcs[i-1][j] > lcs[i][j-1]) ? lcs[i-1][j]
                                                                         : lcs[i][j-1];
                        end
                    end
                    len = lcs[old_cnt][new_cnt];
                    i = old_cnt;
                    j = new_cnt;
                    if (i == 0 && j == 0) begin
                        rec = '{op: OP_EMPTY, old_idx: '0, new_idx: '0, lcs_len: '0, last: 1'b1};
                        expected_ops.push_back(rec);
                    end
                    // Walk back from the bottom right corner; ties go to an add.
                    while (i != 0 || j != 0) begin
                        rec.old_idx = '0;
                        rec.new_idx = '0;
                        rec.lcs_len = LEN_W'(len);
                        if (i == 0) begin
                            rec.op      = OP_ADD;
                            rec.new_idx = IDX_W'(j - 1);
                            j--;
                        end else if (j == 0) begin
                            rec.op      = OP_REMOVE;
                            rec.old_idx = IDX_W'(i - 1);
                            i--;
                        end else if (old_tags[i-1] == new_tags[j-1]) begin
                            rec.op      = OP_KEEP;
                            rec.old_idx = IDX_W'(i - 1);
                            rec.new_idx = IDX_W'(j - 1);
                            i--;
                            j--;
                        end else if (lcs[i-1][j] <= lcs[i][j-1]) begin
                            rec.op      = OP_ADD;
                            rec.new_idx = IDX_W'(j - 1);
                            j--;
                        end else begin
                            rec.op      = OP_REMOVE;
                            rec.old_idx = IDX_W'(i - 1);
                            i--;
                        end
                        rec.last = (i == 0 && j == 0);
                        expected_ops.push_back(rec);
                    end
                    old_cnt = 0;
                    new_cnt = 0;
                end
                default: ;
            endcase
        endfunction

        function void check_op(input logic [1:0] op, input logic [15:0] data, input logic last);
            t_edit_rec want;
            if (expected_ops.size() == 0) begin
                $display("%0t: unexpected edit, expected none, got op %0d data %h last %b",
                         $time, op, data, last);
                errors++;
                return;
            end
            want = expected_ops.pop_front();
            if (op !== want.op) begin
                $display("%0t: edit_op mismatch, expected %0d, got %0d", $time, want.op, op);
                errors++;
            end
            if (data[4:0] !== want.old_idx) begin
                $display("%0t: old_index mismatch, expected %0d, got %0d",
                         $time, want.old_idx, data[4:0]);
                errors++;
            end
            if (data[9:5] !== want.new_idx) begin
                $display("%0t: new_index mismatch, expected %0d, got %0d",
                         $time, want.new_idx, data[9:5]);
                errors++;
            end
            if (data[15:10] !== want.lcs_len) begin
                $display("%0t: lcs_length mismatch, expected %0d, got %0d",
                         $time, want.lcs_len, data[15:10]);
                errors++;
            end
            if (last !== want.last) begin
                $display("%0t: last mismatch, expected %b, got %b", $time, want.last, last);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;   // [31:0] line_tag
    logic [1:0]  s_axis_tuser  = '0;   // [1:0] func
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;         // [4:0] old_index, [9:5] new_index, [15:10] lcs_length
    logic [1:0]  m_axis_tuser;         // [1:0] edit_op
    logic        m_axis_tlast;         // last

    diff_scoreboard sb = new();
    int             burst_left = 0;
    int             items_sent = 0;
    int             rx_mode    = 0;
    int             rx_phase   = 0;
    int             cycles     = 0;

    line_lcs_diff_engine DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Receiver: checks each accepted edit, then picks readiness from a mode that changes now and then.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready)
            sb.check_op(m_axis_tuser, m_axis_tdata, m_axis_tlast);
        if (rx_phase == 0) begin
            rx_mode  = $urandom_range(0, 2);
            rx_phase = $urandom_range(16, 80);
        end else begin
            rx_phase--;
        end
        case (rx_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= 1'($urandom_range(0, 1));
            default: m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // Sends one item, inserting a random gap whenever a burst runs out.
    task automatic send_item(input logic [1:0] func, input logic [31:0] tag);
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= tag;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_item(func, tag);
        items_sent++;
        burst_left--;
    endtask

    // Holds the sender back until every owed edit has come out.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    // Loads both sequences and computes; tags come from a small pool so lines repeat, unless wide_tags is set.
    task automatic run_diff(input int n_old, input int n_new, input bit wide_tags);
        logic [31:0] pool [4];
        int          i;
        for (i = 0; i < 4; i++)
            pool[i] = $urandom;
        for (i = 0; i < n_old; i++) begin
            if ($urandom_range(0, 19) == 0)
                send_item(FUNC_IGNORED, $urandom);
            send_item(FUNC_LOAD_OLD, wide_tags ? $urandom : pool[$urandom_range(0, 3)]);
        end
        for (i = 0; i < n_new; i++) begin
            if ($urandom_range(0, 19) == 0)
                send_item(FUNC_IGNORED, $urandom);
            send_item(FUNC_LOAD_NEW, wide_tags ? $urandom : pool[$urandom_range(0, 3)]);
        end
        if ($urandom_range(0, 5) == 0)
            drain_results();
        send_item(FUNC_COMPUTE, $urandom);
    endtask

    initial begin
        int sel;
        int n_old;
        int n_new;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Both sequences empty, then an ignored function code.
        send_item(FUNC_COMPUTE, 32'h0);
        send_item(FUNC_IGNORED, 32'hFFFF_FFFF);
        // Only an old line, then only a new line.
        send_item(FUNC_LOAD_OLD, 32'h0000_00A5);
        send_item(FUNC_COMPUTE, 32'h0);
        send_item(FUNC_LOAD_NEW, 32'h0000_00A5);
        send_item(FUNC_COMPUTE, 32'h0);
        // One matching line.
        send_item(FUNC_LOAD_OLD, 32'h1234_5678);
        send_item(FUNC_LOAD_NEW, 32'h1234_5678);
        send_item(FUNC_COMPUTE, 32'h0);
        // Differing lines with equal neighbors: the walk takes the add.
        send_item(FUNC_LOAD_OLD, 32'h0000_0001);
        send_item(FUNC_LOAD_NEW, 32'h0000_0002);
        send_item(FUNC_COMPUTE, 32'h0);
        // The cell above wins, so the walk takes the remove.
        send_item(FUNC_LOAD_OLD, 32'h0000_0001);
        send_item(FUNC_LOAD_OLD, 32'h0000_0002);
        send_item(FUNC_LOAD_NEW, 32'h0000_0001);
        send_item(FUNC_COMPUTE, 32'h0);
        // Tag extremes.
        send_item(FUNC_LOAD_OLD, 32'h0000_0000);
        send_item(FUNC_LOAD_OLD, 32'hFFFF_FFFF);
        send_item(FUNC_LOAD_NEW, 32'hFFFF_FFFF);
        send_item(FUNC_LOAD_NEW, 32'h0000_0000);
        send_item(FUNC_COMPUTE, 32'hFFFF_FFFF);
        drain_results();

        // Full-size diff first, with loads past the limit on both sides.
        run_diff(34, 33, 1'b0);
        while (items_sent < ITEM_TARGET) begin
            sel = $urandom_range(0, 15);
            if (sel == 0) begin
                n_old = $urandom_range(MAX_LINES, MAX_LINES + 2);
                n_new = $urandom_range(MAX_LINES, MAX_LINES + 2);
            end else if (sel == 1) begin
                n_old = $urandom_range(20, MAX_LINES);
                n_new = $urandom_range(0, 3);
            end else if (sel == 2) begin
                n_old = $urandom_range(0, 1) * $urandom_range(0, 4);
                n_new = $urandom_range(0, 1) * $urandom_range(0, 4);
            end else begin
                n_old = $urandom_range(0, 6);
                n_new = $urandom_range(0, 6);
            end
            run_diff(n_old, n_new, $urandom_range(0, 3) == 0);
        end

        drain_results();
        repeat (40) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
